### design/kbt_pkg.sv
// Shared constants, types and register codes for the keyed block transposition block.
// Used by kbt_ctrl, kbt_datapath and keyed_block_transposition; depends on nothing.
package kbt_pkg;

    localparam int KEY_MAX_DEF = 8;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 4;
    localparam int KEY_W       = 24;
    localparam int FIELD_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [LEN_W-1:0]  BLOCK_LEN_RESET = 4'd8;
    localparam logic [KEY_W-1:0]  KEY_ORDER_RESET = 24'd16434824;
    localparam logic [CHAR_W-1:0] PAD_FIRST       = 8'h7A;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ORDER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // store the incoming byte, set up pointers
        logic pad_step;  // write one padding byte
        logic rd_issue;  // read the buffer entry for the current position
        logic out_load;  // move the read byte into the output register
        logic run_last;  // the loaded result ends the run of this item
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // incoming byte completes a block
        logic pad_on_end;  // incoming byte ends the message in encrypt mode
        logic pad_done;    // current padding write is the last one
        logic rd_done;     // current result is the last of its block
        logic out_free;    // output register can take a result this cycle
    } t_status;

endpackage

### design/kbt_ctrl.sv
// Controller state machine of the keyed block transposition block.
// Depends on kbt_pkg for the command and status structs.
module kbt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  kbt_pkg::t_status i_status,
    output kbt_pkg::t_cmd   o_cmd,
    output logic            o_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_READ,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_pad_pending;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_valid;
        o_cmd.pad_step = (r_state == S_PAD);
        o_cmd.rd_issue = (r_state == S_READ);
        o_cmd.out_load = (r_state == S_OUT) && i_status.out_free;
        o_cmd.run_last = i_status.rd_done && !r_pad_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pad_pending <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_status.full) begin
                            r_state       <= S_READ;
                            r_pad_pending <= i_status.pad_on_end;
                        end else if (i_status.pad_on_end) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (i_status.pad_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_status.out_free) begin
                        if (!i_status.rd_done) begin
                            r_state <= S_READ;
                        end else if (r_pad_pending) begin
                            r_state       <= S_PAD;
                            r_pad_pending <= 1'b0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### design/kbt_datapath.sv
// Datapath of the keyed block transposition block: registers, block buffer,
// pointers and the output register. Depends on kbt_pkg.
module kbt_datapath #(
    parameter int KEY_MAX = kbt_pkg::KEY_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kbt_pkg::t_cmd                 i_cmd,
    output kbt_pkg::t_status              o_status,
    input  logic [kbt_pkg::CHAR_W-1:0]    i_in_char,
    input  logic                          i_msg_end,
    input  logic                          i_cfg_we,
    input  logic [kbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kbt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [kbt_pkg::CHAR_W-1:0]    o_out_char,
    output logic                          o_run_last
);

    localparam int AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LW = kbt_pkg::LEN_W;

    logic [LW-1:0]              r_block_len;
    logic [kbt_pkg::KEY_W-1:0]  r_key_order;
    logic                       r_decrypt;

    logic [kbt_pkg::CHAR_W-1:0] r_buf [KEY_MAX];
    logic [AW-1:0]              r_pos;
    logic [AW-1:0]              r_pad_ptr;
    logic [AW-1:0]              r_pad_cnt;
    logic [AW-1:0]              r_y;
    logic [kbt_pkg::CHAR_W-1:0] r_rdata;
    logic                       r_src_ok;
    logic                       r_out_valid;
    logic [kbt_pkg::CHAR_W-1:0] r_out_char;
    logic                       r_run_last;

    logic [LW-1:0]                 len;
    logic [kbt_pkg::FIELD_W-1:0]   key_pos;
    logic [kbt_pkg::FIELD_W-1:0]   key_y;
    logic [LW-1:0]                 pos_inc;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [kbt_pkg::CHAR_W-1:0]    wr_data;
    logic [AW-1:0]                 rd_addr;
    logic                          rd_ok;

    // Effective block length, clamped to 2..KEY_MAX.
    always_comb begin
        if (r_block_len < LW'(2)) begin
            len = LW'(2);
        end else if (r_block_len > LW'(KEY_MAX)) begin
            len = LW'(KEY_MAX);
        end else begin
            len = r_block_len;
        end
    end

    assign key_pos = r_key_order[kbt_pkg::FIELD_W*r_pos +: kbt_pkg::FIELD_W];
    assign key_y   = r_key_order[kbt_pkg::FIELD_W*r_y +: kbt_pkg::FIELD_W];
    assign pos_inc = LW'(r_pos) + LW'(1);

    assign o_status.full       = (pos_inc >= len);
    assign o_status.pad_on_end = i_msg_end && !r_decrypt;
    assign o_status.pad_done   = ((LW'(r_pad_ptr) + LW'(1)) >= len);
    assign o_status.rd_done    = ((LW'(r_y) + LW'(1)) >= len);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // Single write port shared by byte stores and padding.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = i_in_char;
        if (i_cmd.accept) begin
            if (r_decrypt) begin
                wr_en   = (LW'(key_pos) < len);
                wr_addr = AW'(key_pos);
            end else begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
            end
        end else if (i_cmd.pad_step) begin
            wr_en   = 1'b1;
            wr_addr = r_pad_ptr;
            wr_data = kbt_pkg::PAD_FIRST - kbt_pkg::CHAR_W'(r_pad_cnt);
        end
    end

    // Encrypt reads the keyed source, decrypt reads in order.
    always_comb begin
        if (r_decrypt) begin
            rd_addr = r_y;
            rd_ok   = 1'b1;
        end else begin
            rd_addr = AW'(key_y);
            rd_ok   = (LW'(key_y) < len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rdata  <= r_buf[rd_addr];
            r_src_ok <= rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= kbt_pkg::BLOCK_LEN_RESET;
            r_key_order <= kbt_pkg::KEY_ORDER_RESET;
            r_decrypt   <= 1'b0;
            r_pos       <= '0;
            r_pad_ptr   <= '0;
            r_pad_cnt   <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kbt_pkg::CFG_BLOCK_LEN:    r_block_len <= i_cfg_data[LW-1:0];
                    kbt_pkg::CFG_KEY_ORDER:    r_key_order <= i_cfg_data[kbt_pkg::KEY_W-1:0];
                    kbt_pkg::CFG_DECRYPT_MODE: r_decrypt   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_y       <= '0;
                r_pad_cnt <= '0;
                if (o_status.full) begin
                    r_pos     <= '0;
                    r_pad_ptr <= '0;
                end else begin
                    r_pos     <= i_msg_end ? '0 : AW'(pos_inc);
                    r_pad_ptr <= AW'(pos_inc);
                end
            end
            if (i_cmd.pad_step) begin
                r_pad_ptr <= r_pad_ptr + AW'(1);
                r_pad_cnt <= r_pad_cnt + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_y <= o_status.rd_done ? '0 : (r_y + AW'(1));
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_char <= r_src_ok ? r_rdata : '0;
            r_run_last <= i_cmd.run_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_run_last  = r_run_last;

endmodule

### design/keyed_block_transposition.sv
// Top level of the keyed block transposition block.
// Instantiates kbt_ctrl and kbt_datapath; depends on kbt_pkg.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_in_char, i_msg_end
// result    out        o_valid / i_stall         o_out_char, o_run_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A byte that does not finish a block is taken without stalling the input. Each
// result is read from the block buffer into its read register and then loaded
// into the output register. Padding at message end writes the padded bytes one
// at a time before the block is sent.
// Reset (i_rst_n low at a clock edge) restores the register defaults, empties
// the open block and drops any result not yet taken; the buffer is not cleared.
// A stall on the result side holds the output register and halts emission, and
// the input side is stalled for as long as a block is being padded or sent.
//
// The block gathers message bytes into blocks of block_len bytes. In encrypt
// mode result y of a block carries block position key[y]; in decrypt mode input
// byte y is stored at key[y] and the block is sent in order. At message end,
// encrypt fills the open block with 'z', 'y', 'x', ... and sends it, which gives
// a whole padding block when the message length is a multiple of block_len.
// Decrypt simply drops an open partial block. o_run_last marks the final result
// caused by one input item.
module keyed_block_transposition #(
    parameter int KEY_MAX = kbt_pkg::KEY_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [kbt_pkg::CHAR_W-1:0]     i_in_char,
    input  logic                           i_msg_end,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [kbt_pkg::CHAR_W-1:0]     o_out_char,
    output logic                           o_run_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kbt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    kbt_pkg::t_cmd    cmd;
    kbt_pkg::t_status status;

    // Configuration writes are always taken; the user must send them only while idle (the block does not check).
    assign o_cfg_ready = 1'b1;

    kbt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    kbt_datapath #(
        .KEY_MAX (KEY_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_char   (i_in_char),
        .i_msg_end   (i_msg_end),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last)
    );

endmodule

### design/kbt_checker.sv
// Port-level checks for keyed_block_transposition, attached by the bind below.
// Depends on kbt_pkg for port widths.
module kbt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [kbt_pkg::CHAR_W-1:0]     i_in_char,
    input logic                           i_msg_end,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [kbt_pkg::CHAR_W-1:0]     o_out_char,
    input logic                           o_run_last
);

    // A stalled input item stays on the pins unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_in_char) && $stable(i_msg_end))
        else $error("stalled input item changed");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_run_last))
        else $error("stalled result changed");

    // Reset leaves no pending result and an open input side.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset did not clear the handshakes");

    // A new result only appears while a block is being sent.
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while idle");

    // Inside a run the input stays stalled until its final result is loaded.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_run_last |-> o_stall)
        else $error("input opened in the middle of a run");

endmodule

bind keyed_block_transposition kbt_checker u_kbt_checker (.*);
